// ===== design/streaming_ks_distance_assert.svh =====
// ---------------------------------------------------------------------------
// streaming_ks_distance assertion macros
// Short forms for clocked assertions with a synchronous reset disable.
// ---------------------------------------------------------------------------
`ifndef STREAMING_KS_DISTANCE_ASSERT_SVH
`define STREAMING_KS_DISTANCE_ASSERT_SVH

// same-cycle implication
`define SKSD_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed in %m");

// next-cycle implication
`define SKSD_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed in %m");

`endif

// ===== design/sksd_pkg.sv =====
// ---------------------------------------------------------------------------
// sksd_pkg
// Shared constants, types and codes of the streaming ks distance block.
// ---------------------------------------------------------------------------
`default_nettype none

package sksd_pkg;

   localparam int NUM_BINS  = 16;
   localparam int BIN_IDX_W = (NUM_BINS > 1) ? $clog2(NUM_BINS) : 1;
   localparam int THR_W     = 32 + BIN_IDX_W;
   localparam int CNT_W     = 31;
   localparam logic [CNT_W-1:0] CNT_MAX = '1;

   // item kind codes on the input channel
   localparam logic [1:0] KIND_SAMPLE = 2'd0;
   localparam logic [1:0] KIND_CLEAR  = 2'd1;
   localparam logic [1:0] KIND_LOAD   = 2'd2;

   typedef enum logic [1:0] {
      OP_SAMPLE,
      OP_CLEAR,
      OP_LOAD,
      OP_NONE
   } op_type;

   typedef struct packed {
      op_type                 op;
      logic [31:0]            sample;
      logic [BIN_IDX_W-1:0]   idx;
      logic [CNT_W-1:0]       value;
   } cmd_type;

   typedef struct packed {
      logic    valid;
      cmd_type cmd;
   } cmd_chan_type;

   typedef enum logic {
      ENG_IDLE,
      ENG_WALK
   } eng_state_type;

endpackage

`default_nettype wire

// ===== design/sksd_front.sv =====
// ---------------------------------------------------------------------------
// sksd_front
// Accepts items, decodes them into commands and holds them in a two-entry
// command queue for the bin engine.
// ---------------------------------------------------------------------------
`default_nettype none

module sksd_front (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_push,
   output logic                       req_full,
   input  wire logic [1:0]            req_kind,
   input  wire logic [31:0]           req_sample_value,
   input  wire logic [3:0]            req_entry_index,
   input  wire logic [30:0]           req_entry_value,
   output sksd_pkg::cmd_chan_type     cmd_out,
   input  wire logic                  cmd_pop
);
   import sksd_pkg::*;

   cmd_type    slot_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   cmd_type    dec;
   logic       push_ok, pop_ok;

   always_comb begin
      dec.sample = req_sample_value;
      dec.idx    = BIN_IDX_W'(32'(req_entry_index));
      dec.value  = req_entry_value;
      case (req_kind)
         KIND_SAMPLE: dec.op = OP_SAMPLE;
         KIND_CLEAR:  dec.op = OP_CLEAR;
         KIND_LOAD: begin
            // a load beyond the table does nothing
            dec.op = (32'(req_entry_index) < 32'(NUM_BINS)) ? OP_LOAD : OP_NONE;
         end
         default:     dec.op = OP_NONE;
      endcase
   end

   assign req_full      = (count_ff == 2'd2);
   assign push_ok       = req_push && !req_full;
   assign pop_ok        = cmd_pop && (count_ff != 2'd0);
   assign cmd_out.valid = (count_ff != 2'd0);
   assign cmd_out.cmd   = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push_ok ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop_ok ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + 2'(push_ok) - 2'(pop_ok);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_ok) begin
         slot_ff[wr_ptr_ff] <= dec;
      end
   end

endmodule

`default_nettype wire

// ===== design/sksd_engine.sv =====
// ---------------------------------------------------------------------------
// sksd_engine
// Walks all bins once per command, one bin per cycle: updates the empirical
// count and expected entry of the bin and tracks the largest difference.
// ---------------------------------------------------------------------------
`default_nettype none

module sksd_engine (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic [31:0]                   bin_width,
   input  wire sksd_pkg::cmd_chan_type        cmd_in,
   output logic                               cmd_pop,
   input  wire logic                          rsp_full,
   output logic                               rsp_push,
   output logic [sksd_pkg::CNT_W-1:0]         rsp_data
);
   import sksd_pkg::*;

   eng_state_type          state_ff, state_in;
   cmd_type                cur_ff;
   logic [BIN_IDX_W-1:0]   bin_ff, bin_in;
   logic [THR_W-1:0]       thr_ff, thr_in;
   logic [CNT_W-1:0]       best_ff, best_in;
   logic [CNT_W-1:0]       cnt_ff [NUM_BINS];
   logic [CNT_W-1:0]       exp_ff [NUM_BINS];

   logic [CNT_W-1:0]       c_rd, e_rd, c_plus, c_new, e_new, diff;
   logic                   hit, last, start, walk;

   always_comb begin
      c_rd   = cnt_ff[bin_ff];
      e_rd   = exp_ff[bin_ff];
      // threshold is bin index times bin width, kept as a running sum
      hit    = THR_W'(cur_ff.sample) >= thr_ff;
      c_plus = (c_rd == CNT_MAX) ? c_rd : c_rd + CNT_W'(1);
      case (cur_ff.op)
         OP_SAMPLE: c_new = hit ? c_plus : c_rd;
         OP_CLEAR:  c_new = '0;
         default:   c_new = c_rd;
      endcase
      e_new   = (cur_ff.op == OP_LOAD && cur_ff.idx == bin_ff) ? cur_ff.value : e_rd;
      diff    = (e_new >= c_new) ? e_new - c_new : c_new - e_new;
      best_in = (diff > best_ff) ? diff : best_ff;
      last    = (bin_ff == BIN_IDX_W'(NUM_BINS - 1));
   end

   always_comb begin
      state_in = state_ff;
      start    = 1'b0;
      walk     = 1'b0;
      bin_in   = bin_ff;
      thr_in   = thr_ff;
      case (state_ff)
         ENG_IDLE: begin
            // a free result slot stays free until this command finishes
            if (cmd_in.valid && !rsp_full) begin
               start    = 1'b1;
               state_in = ENG_WALK;
               bin_in   = '0;
               thr_in   = '0;
            end
         end
         ENG_WALK: begin
            walk   = 1'b1;
            bin_in = bin_ff + BIN_IDX_W'(1);
            thr_in = thr_ff + THR_W'(bin_width);
            if (last) begin
               state_in = ENG_IDLE;
            end
         end
         default: state_in = ENG_IDLE;
      endcase
   end

   assign cmd_pop  = start;
   assign rsp_push = walk && last;
   assign rsp_data = best_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ENG_IDLE;
         for (int i = 0; i < NUM_BINS; i++) begin
            cnt_ff[i] <= '0;
            exp_ff[i] <= '0;
         end
      end else begin
         state_ff <= state_in;
         if (walk) begin
            cnt_ff[bin_ff] <= c_new;
            exp_ff[bin_ff] <= e_new;
         end
      end
   end

   always_ff @(posedge clock) begin
      bin_ff <= bin_in;
      thr_ff <= thr_in;
      if (start) begin
         cur_ff  <= cmd_in.cmd;
         best_ff <= '0;
      end else if (walk) begin
         best_ff <= best_in;
      end
   end

endmodule

`default_nettype wire

// ===== design/sksd_rsp_queue.sv =====
// ---------------------------------------------------------------------------
// sksd_rsp_queue
// Two-entry result queue that drives the result channel.
// ---------------------------------------------------------------------------
`default_nettype none

module sksd_rsp_queue (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       push,
   input  wire logic [sksd_pkg::CNT_W-1:0] push_data,
   output logic                            full,
   output logic                            rsp_empty,
   input  wire logic                       rsp_pop,
   output logic [sksd_pkg::CNT_W-1:0]      rsp_distance
);
   import sksd_pkg::*;

   logic [CNT_W-1:0] slot_ff [2];
   logic             wr_ptr_ff, rd_ptr_ff;
   logic [1:0]       count_ff, count_in;
   logic             push_ok, pop_ok;

   assign full         = (count_ff == 2'd2);
   assign rsp_empty    = (count_ff == 2'd0);
   assign push_ok      = push && !full;
   assign pop_ok       = rsp_pop && !rsp_empty;
   assign rsp_distance = slot_ff[rd_ptr_ff];
   assign count_in     = count_ff + 2'(push_ok) - 2'(pop_ok);

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_ff ^ push_ok;
         rd_ptr_ff <= rd_ptr_ff ^ pop_ok;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_ok) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

`default_nettype wire

// ===== design/streaming_ks_distance.sv =====
// ---------------------------------------------------------------------------
// streaming_ks_distance
// Binned empirical cdf against a loaded expected table; reports the largest
// absolute difference after every item.
// ---------------------------------------------------------------------------
//   Input queue (req_push / req_full): kind 0 adds a sample to every bin whose
//   threshold (bin index times bin width) does not exceed it, kind 1 clears
//   the counts, kind 2 loads one expected entry, kind 3 changes nothing.
//   Result queue (rsp_empty / rsp_pop): one distance per item, in order.
//   csr channel (csr_valid / csr_ready): sets the bin width; ready is always
//   high. The user must see that it is written only while no item is in
//   flight; the block itself does not enforce this. The bin engine visits
//   one bin per cycle and takes the next item only after walking every bin
//   for the last one, so it sets the throughput. A two-entry command queue
//   lets the input side take items while the engine works, and a two-entry
//   result queue holds results while pop is low; the engine waits when that
//   queue is full and req_full rises once the command queue fills. Reset
//   clears counts and expected table, sets bin width to 1 and empties both
//   queues.
// ---------------------------------------------------------------------------
`default_nettype none

module streaming_ks_distance (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_push,
   output logic             req_full,
   input  wire logic [1:0]  req_kind,
   input  wire logic [31:0] req_sample_value,
   input  wire logic [3:0]  req_entry_index,
   input  wire logic [30:0] req_entry_value,
   output logic             rsp_empty,
   input  wire logic        rsp_pop,
   output logic [30:0]      rsp_distance,
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [31:0] csr_data
);
   import sksd_pkg::*;

   logic [31:0]      bin_width_ff;
   cmd_chan_type     cmd_chan;
   logic             cmd_pop;
   logic             rsp_q_full;
   logic             rsp_push;
   logic [CNT_W-1:0] rsp_data;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         bin_width_ff <= 32'd1;
      end else if (csr_valid && csr_ready) begin
         bin_width_ff <= csr_data;
      end
   end

   sksd_front u_front (
      .clock            (clock),
      .reset            (reset),
      .req_push         (req_push),
      .req_full         (req_full),
      .req_kind         (req_kind),
      .req_sample_value (req_sample_value),
      .req_entry_index  (req_entry_index),
      .req_entry_value  (req_entry_value),
      .cmd_out          (cmd_chan),
      .cmd_pop          (cmd_pop)
   );

   sksd_engine u_engine (
      .clock     (clock),
      .reset     (reset),
      .bin_width (bin_width_ff),
      .cmd_in    (cmd_chan),
      .cmd_pop   (cmd_pop),
      .rsp_full  (rsp_q_full),
      .rsp_push  (rsp_push),
      .rsp_data  (rsp_data)
   );

   sksd_rsp_queue u_rsp_queue (
      .clock        (clock),
      .reset        (reset),
      .push         (rsp_push),
      .push_data    (rsp_data),
      .full         (rsp_q_full),
      .rsp_empty    (rsp_empty),
      .rsp_pop      (rsp_pop),
      .rsp_distance (rsp_distance)
   );

endmodule

`default_nettype wire

// ===== design/sksd_checker.sv =====
// ---------------------------------------------------------------------------
// sksd_checker
// Port-level checks of the streaming ks distance block, bound to the top.
// ---------------------------------------------------------------------------
`default_nettype none

`include "streaming_ks_distance_assert.svh"

module sksd_checker (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_push,
   input  wire logic        req_full,
   input  wire logic        rsp_empty,
   input  wire logic        rsp_pop,
   input  wire logic [30:0] rsp_distance
);

   // a waiting result stays until popped
   `SKSD_ASSERT_NEXT(a_rsp_held, clock, reset, !rsp_empty && !rsp_pop, !rsp_empty)
   `SKSD_ASSERT_NEXT(a_rsp_stable, clock, reset, !rsp_empty && !rsp_pop, $stable(rsp_distance))
   // the input queue only fills by accepting an item
   `SKSD_ASSERT_NEXT(a_full_needs_push, clock, reset, !req_full && !req_push, !req_full)
   // no result can be ready right after reset
   `SKSD_ASSERT_NOW(a_empty_after_reset, clock, reset, $past(reset), rsp_empty)

endmodule

bind streaming_ks_distance sksd_checker u_checker (.*);

`default_nettype wire

// ===== sim/testbench.sv =====
// ---------------------------------------------------------------------------
// testbench
// Checks the streaming ks distance block against its own model of the bin
// counts and expected table. Items go in through a bursty queue driver, and
// distances come back through a stalling monitor. The bin width is changed
// between phases, including zero, all ones and a large power of two.
// ---------------------------------------------------------------------------
`default_nettype none

module testbench;
   import sksd_pkg::*;

   localparam int SETTLE_CYCLES = 30;
   localparam int WATCHDOG_LIMIT = 3000;
   localparam int RANDOM_PER_PHASE = 82;
   localparam int NUM_PHASES = 7;

   typedef struct {
      op_type      op;
      logic [31:0] sample;
      logic [3:0]  index;
      logic [30:0] value;
      bit          drain;
   } ks_item_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_push = 1'b0;
   logic        req_full;
   logic [1:0]  req_kind = '0;
   logic [31:0] req_sample_value = '0;
   logic [3:0]  req_entry_index = '0;
   logic [30:0] req_entry_value = '0;
   logic        rsp_empty;
   logic        rsp_pop = 1'b0;
   logic [30:0] rsp_distance;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [31:0] csr_data = '0;

   // model state
   logic [CNT_W-1:0] bin_count [NUM_BINS];
   logic [CNT_W-1:0] exp_table [NUM_BINS];
   logic [31:0]      bin_width_model;

   ks_item_type      item_q[$];
   logic [30:0]      pending_dist[$];
   ks_item_type      cur_item;

   int burst_left = 1;
   int gap_left = 0;
   logic [31:0] pop_pattern = '1;
   int pop_tick = 0;
   int idle_cycles = 0;
   int error_count = 0;
   int items_in = 0;
   int results_seen = 0;
   int kind_count [4] = '{0, 0, 0, 0};

   streaming_ks_distance dut (
      .clock            (clock),
      .reset            (reset),
      .req_push         (req_push),
      .req_full         (req_full),
      .req_kind         (req_kind),
      .req_sample_value (req_sample_value),
      .req_entry_index  (req_entry_index),
      .req_entry_value  (req_entry_value),
      .rsp_empty        (rsp_empty),
      .rsp_pop          (rsp_pop),
      .rsp_distance     (rsp_distance),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_data         (csr_data)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // updates the counts and table for one item, returns the new distance
   function automatic logic [30:0] apply_item(ks_item_type it);
      logic [63:0]      thr;
      logic [CNT_W-1:0] diff;
      logic [CNT_W-1:0] best;
      int k;
      best = '0;
      case (it.op)
         OP_SAMPLE: begin
            for (k = 0; k < NUM_BINS; k++) begin
               // threshold at full width, no wrap
               thr = 64'(k) * 64'(bin_width_model);
               if (64'(it.sample) >= thr && bin_count[k] != CNT_MAX)
                  bin_count[k] = bin_count[k] + 1'b1;
            end
         end
         OP_CLEAR: begin
            for (k = 0; k < NUM_BINS; k++)
               bin_count[k] = '0;
         end
         OP_LOAD: begin
            exp_table[it.index] = it.value;
         end
         default: begin
         end
      endcase
      for (k = 0; k < NUM_BINS; k++) begin
         diff = (exp_table[k] >= bin_count[k]) ? exp_table[k] - bin_count[k]
                                               : bin_count[k] - exp_table[k];
         if (diff > best)
            best = diff;
      end
      return best;
   endfunction

   function automatic ks_item_type mk_item(op_type op, logic [31:0] s, logic [3:0] ix,
                                           logic [30:0] v);
      ks_item_type it;
      it.op = op;
      it.sample = s;
      it.index = ix;
      it.value = v;
      it.drain = 1'b0;
      return it;
   endfunction

   function automatic ks_item_type random_item();
      ks_item_type it;
      logic [63:0] base;
      int          pick;
      int          k;
      it = mk_item(OP_SAMPLE, $urandom, 4'($urandom), 31'($urandom));
      pick = $urandom_range(0, 99);
      if (pick < 60) begin
         it.op = OP_SAMPLE;
         pick = $urandom_range(0, 9);
         k = $urandom_range(0, NUM_BINS);
         base = 64'(k) * 64'(bin_width_model);
         if (pick < 6 && base <= 64'hFFFF_FFFF) begin
            // land on or right next to a threshold
            it.sample = base[31:0] + 32'($urandom_range(0, 2)) - 32'd1;
         end else if (pick == 8) begin
            it.sample = '0;
         end else if (pick == 9) begin
            it.sample = '1;
         end
      end else if (pick < 85) begin
         it.op = OP_LOAD;
         pick = $urandom_range(0, 3);
         if (pick == 0)
            it.value = 31'($urandom_range(0, 64));
         else if (pick == 1)
            it.value = CNT_MAX;
         else if (pick == 2)
            it.value = bin_count[it.index] + 31'($urandom_range(0, 4));
      end else if (pick < 91) begin
         it.op = OP_CLEAR;
      end else begin
         it.op = OP_NONE;
      end
      it.drain = ($urandom_range(0, 99) < 3);
      return it;
   endfunction

   // sender: bursts of items with random gaps
   always @(posedge clock) begin
      logic launch;
      ks_item_type nxt;
      if (reset) begin
         req_push <= 1'b0;
      end else begin
         launch = 1'b0;
         if (req_push && !req_full) begin
            pending_dist.push_back(apply_item(cur_item));
            items_in++;
            kind_count[cur_item.op]++;
         end
         if (req_push && req_full) begin
            // hold the item until taken
         end else if (gap_left > 0) begin
            gap_left--;
         end else if (item_q.size() > 0 &&
                      !(item_q[0].drain && pending_dist.size() > 0)) begin
            nxt = item_q.pop_front();
            cur_item = nxt;
            launch = 1'b1;
            req_kind <= nxt.op;
            req_sample_value <= nxt.sample;
            req_entry_index <= nxt.index;
            req_entry_value <= nxt.value;
            if (burst_left > 1) begin
               burst_left--;
            end else begin
               burst_left = $urandom_range(1, 40);
               gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 24);
            end
         end
         if (!(req_push && req_full))
            req_push <= launch;
      end
   end

   // receiver: rotating stall pattern, reloaded with a random choice on pop_tick
   always @(posedge clock) begin
      if (reset) begin
         rsp_pop <= 1'b0;
      end else begin
         pop_tick++;
         if (pop_tick % 64 == 0) begin
            case ($urandom_range(0, 3))
               0: pop_pattern = '1;
               1: pop_pattern = $urandom;
               2: pop_pattern = $urandom & $urandom & $urandom;
               default: pop_pattern = 32'h0000_0001;
            endcase
         end
         rsp_pop <= pop_pattern[0];
         pop_pattern = {pop_pattern[0], pop_pattern[31:1]};
      end
   end

   always @(posedge clock) begin
      logic [30:0] want;
      if (!reset && rsp_pop && !rsp_empty) begin
         if (pending_dist.size() == 0) begin
            $error("distance %0d arrived with no item outstanding", rsp_distance);
            error_count++;
         end else begin
            want = pending_dist.pop_front();
            results_seen++;
            if (rsp_distance !== want) begin
               $error("distance mismatch: expected %0d, actual %0d", want, rsp_distance);
               error_count++;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_push && !req_full) || (rsp_pop && !rsp_empty) ||
          (csr_valid && csr_ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("watchdog: no transfer for %0d cycles, %0d distances still due",
                  idle_cycles, pending_dist.size());
         $display("TEST FAILED");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   task automatic wait_drained();
      while (item_q.size() > 0 || req_push || pending_dist.size() > 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_bin_width(logic [31:0] w);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_data <= w;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      bin_width_model = w;
   endtask

   initial begin
      logic [31:0] widths [NUM_PHASES];
      ks_item_type it;
      int          ph;
      int          n;
      bin_width_model = 32'd1;
      for (n = 0; n < NUM_BINS; n++) begin
         bin_count[n] = '0;
         exp_table[n] = '0;
      end
      widths = '{32'd1, 32'd0, 32'hFFFF_FFFF, 32'($urandom_range(2, 300)),
                 32'h8000_0000, $urandom, 32'd1};
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // directed items at the reset bin width of one
      item_q.push_back(mk_item(OP_SAMPLE, 32'd0, 4'd0, 31'd0));
      item_q.push_back(mk_item(OP_SAMPLE, 32'hFFFF_FFFF, 4'd0, 31'd0));
      item_q.push_back(mk_item(OP_SAMPLE, 32'd15, 4'd0, 31'd0));
      item_q.push_back(mk_item(OP_SAMPLE, 32'd16, 4'd0, 31'd0));
      item_q.push_back(mk_item(OP_SAMPLE, 32'd7, 4'd0, 31'd0));
      item_q.push_back(mk_item(OP_NONE, 32'd0, 4'd0, 31'd0));
      item_q.push_back(mk_item(OP_LOAD, 32'd0, 4'd0, CNT_MAX));
      item_q.push_back(mk_item(OP_LOAD, 32'd0, 4'd15, 31'd0));
      item_q.push_back(mk_item(OP_LOAD, 32'hFFFF_FFFF, 4'd8, 31'h2AAA_AAAA));
      item_q.push_back(mk_item(OP_LOAD, 32'd0, 4'd7, 31'h5555_5555));
      item_q.push_back(mk_item(OP_SAMPLE, 32'hAAAA_AAAA, 4'd5, 31'h5555_5555));
      item_q.push_back(mk_item(OP_SAMPLE, 32'h5555_5555, 4'd10, 31'h2AAA_AAAA));
      item_q.push_back(mk_item(OP_CLEAR, 32'd0, 4'd0, 31'd0));
      // unused kind with every field at its top
      item_q.push_back(mk_item(OP_NONE, 32'hFFFF_FFFF, 4'd15, CNT_MAX));
      item_q.push_back(mk_item(OP_SAMPLE, 32'd14, 4'd0, 31'd0));
      item_q.push_back(mk_item(OP_LOAD, 32'd0, 4'd0, 31'd0));
      item_q.push_back(mk_item(OP_LOAD, 32'd0, 4'd7, 31'd0));
      item_q.push_back(mk_item(OP_LOAD, 32'd0, 4'd8, 31'd0));
      item_q.push_back(mk_item(OP_LOAD, 32'd0, 4'd3, 31'd5));
      item_q.push_back(mk_item(OP_SAMPLE, 32'd3, 4'd0, 31'd0));
      item_q.push_back(mk_item(OP_SAMPLE, 32'd2, 4'd0, 31'd0));
      item_q.push_back(mk_item(OP_CLEAR, 32'hFFFF_FFFF, 4'd15, CNT_MAX));

      for (ph = 0; ph < NUM_PHASES; ph++) begin
         if (ph > 0) begin
            wait_drained();
            write_bin_width(widths[ph]);
         end
         for (n = 0; n < RANDOM_PER_PHASE; n++) begin
            it = random_item();
            // first item of each phase waits for all distances to come back
            if (n == 0)
               it.drain = 1'b1;
            item_q.push_back(it);
         end
      end

      wait_drained();
      $display("ran %0d items over %0d bin widths:", items_in, NUM_PHASES);
      $display("%0d samples, %0d clears, %0d loads, %0d no-ops",
               kind_count[OP_SAMPLE], kind_count[OP_CLEAR],
               kind_count[OP_LOAD], kind_count[OP_NONE]);
      $display("checked %0d distances, %0d errors", results_seen, error_count);
      if (error_count == 0)
         $display("TEST PASSED");
      else
         $display("TEST FAILED");
      $finish;
   end

endmodule

`default_nettype wire

// ===== sim.f =====
+incdir+design
design/sksd_pkg.sv
design/sksd_front.sv
design/sksd_engine.sv
design/sksd_rsp_queue.sv
design/streaming_ks_distance.sv
design/sksd_checker.sv
sim/testbench.sv
